// File: src/asvm_pkg.sv
// Package for the ADC scan voltage monitor: constants, codes and types.
package asvm_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int THRESH_W      = 10;
  localparam int VOLTS_W       = 5;
  localparam int HUND_W        = 7;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CAP_SHIFT  = 4;
  localparam int CAP_DIV    = 1023;
  localparam int SERIES_MUL = 391;
  localparam int MUL_W      = 9;
  localparam int SERIES_DIV = 12500;
  localparam int DIVISOR_W  = 14;
  localparam int HUND_SCALE = 100;
  localparam int THRESH_RST = 400;

  localparam int PROD_W = SAMPLE_W + MUL_W;

  localparam logic REG_SERIES_MODE = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef enum logic [1:0] {
    CH_THROTTLE = 2'd0,
    CH_CAP_ONE  = 2'd1,
    CH_SUPPLY   = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPLIT,
    ST_EMIT
  } state_t;

endpackage

// File: src/adc_scan_voltage_monitor_unit.sv
// Top level of the ADC scan voltage monitor: channel scan, serial divider and result register.
//
// Each accepted conversion result gives one result transaction. A throttle sample passes
// through the emit state into the result register. A capacitor-one or supply sample runs
// through a bit-serial restoring divider that retires one quotient bit per cycle over
// 19 + FRAC_BITS numerator bits; a capacitor-one sample then goes to the emit state and
// a supply sample through the split state to the emit state, and the unit returns to idle
// before the next sample is taken, so the divider length limits the rate. Capacitor one is
// converted when its sample arrives, capacitor two when the supply sample arrives. A new
// sample is taken as soon as the previous one has reached the result register, even while
// that result still waits downstream. Voltage fields hold the values from the last supply
// sample; the values behind them reset to zero and reach the outputs with the next result.
module adc_scan_voltage_monitor_unit #(
  parameter int FRAC_BITS = asvm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [asvm_pkg::SAMPLE_W-1:0]  conversion_result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [asvm_pkg::THRESH_W-1:0]  cfg_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     next_channel,
  output logic                           throttle_above,
  output logic                           voltages_updated,
  output logic [asvm_pkg::VOLTS_W-1:0]   cap_one_volts,
  output logic [asvm_pkg::HUND_W-1:0]    cap_one_hundredths,
  output logic [asvm_pkg::VOLTS_W-1:0]   cap_two_volts,
  output logic [asvm_pkg::HUND_W-1:0]    cap_two_hundredths
);
  import asvm_pkg::*;

  localparam int NUM_W   = PROD_W + FRAC_BITS;
  localparam int Q_W     = VOLTS_W + FRAC_BITS;
  localparam int REM_W   = DIVISOR_W;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int HPROD_W = FRAC_BITS + HUND_W;

  state_t                 state;
  state_t                 state_next;
  chan_t                  channel_index;
  logic                   series_mode;
  logic [THRESH_W-1:0]    throttle_threshold;
  logic [SAMPLE_W-1:0]    throttle_sample;

  logic [NUM_W-1:0]       num_sr;
  logic [REM_W-1:0]       rem;
  logic [Q_W-1:0]         quo;
  logic [CNT_W-1:0]       bit_cnt;
  logic                   use_series;
  logic                   job_c2;
  logic                   updated;
  logic [Q_W-1:0]         c1_fx;
  logic [Q_W-1:0]         c2_fx;

  logic [VOLTS_W-1:0]     v1;
  logic [HUND_W-1:0]      h1;
  logic [VOLTS_W-1:0]     v2;
  logic [HUND_W-1:0]      h2;

  logic                   sample_take;
  logic                   result_load;
  logic                   div_last;
  logic [REM_W:0]         rem_sh;
  logic [REM_W:0]         divisor;
  logic                   q_bit;
  logic [REM_W-1:0]       rem_step;
  logic [Q_W-1:0]         quo_step;
  logic [PROD_W-1:0]      series_prod;
  logic [NUM_W-1:0]       num_cap;
  logic [NUM_W-1:0]       num_series;
  logic [HPROD_W-1:0]     h1_prod;
  logic [HPROD_W-1:0]     h2_prod;

  assign cfg_ready   = 1'b1;
  assign sample_take = sample_valid && !sample_stall;
  assign div_last    = (state == ST_DIV) && (bit_cnt == '0);

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    result_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          if (channel_index == CH_CAP_ONE || channel_index == CH_SUPPLY) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = job_c2 ? ST_SPLIT : ST_EMIT;
        end
      end
      ST_SPLIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        result_load = !result_valid || !result_stall;
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring division step, one quotient bit per cycle
  assign rem_sh   = {rem, num_sr[NUM_W-1]};
  assign divisor  = use_series ? (REM_W+1)'(SERIES_DIV) : (REM_W+1)'(CAP_DIV);
  assign q_bit    = (rem_sh >= divisor);
  assign rem_step = q_bit ? REM_W'(rem_sh - divisor) : rem_sh[REM_W-1:0];
  assign quo_step = {quo[Q_W-2:0], q_bit};

  assign series_prod = PROD_W'(conversion_result) * PROD_W'(SERIES_MUL);
  assign num_cap     = NUM_W'(conversion_result) << (CAP_SHIFT + FRAC_BITS);
  assign num_series  = NUM_W'(series_prod) << FRAC_BITS;

  assign h1_prod = HPROD_W'(c1_fx[FRAC_BITS-1:0]) * HPROD_W'(HUND_SCALE);
  assign h2_prod = HPROD_W'(c2_fx[FRAC_BITS-1:0]) * HPROD_W'(HUND_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      series_mode        <= 1'b0;
      throttle_threshold <= THRESH_W'(THRESH_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SERIES_MODE: series_mode        <= cfg_data[0];
        REG_THRESHOLD:   throttle_threshold <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index   <= CH_THROTTLE;
      throttle_sample <= '0;
    end else if (sample_take) begin
      case (channel_index)
        CH_THROTTLE: begin
          throttle_sample <= conversion_result;
          channel_index   <= CH_CAP_ONE;
        end
        CH_CAP_ONE: channel_index <= CH_SUPPLY;
        CH_SUPPLY:  channel_index <= CH_THROTTLE;
        default:    channel_index <= CH_THROTTLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      updated    <= (channel_index == CH_SUPPLY);
      job_c2     <= (channel_index == CH_SUPPLY);
      use_series <= (channel_index == CH_SUPPLY) && series_mode;
      num_sr     <= ((channel_index == CH_SUPPLY) && series_mode) ? num_series : num_cap;
      rem        <= '0;
      quo        <= '0;
      bit_cnt    <= CNT_W'(NUM_W - 1);
    end else if (state == ST_DIV) begin
      num_sr  <= {num_sr[NUM_W-2:0], 1'b0};
      rem     <= rem_step;
      quo     <= quo_step;
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_last) begin
      if (!job_c2) begin
        c1_fx <= quo_step;
      end else if (!use_series) begin
        c2_fx <= quo_step;
      end else begin
        c2_fx <= (quo_step > c1_fx) ? (quo_step - c1_fx) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
      h1 <= '0;
      v2 <= '0;
      h2 <= '0;
    end else if (state == ST_SPLIT) begin
      v1 <= c1_fx[Q_W-1:FRAC_BITS];
      h1 <= h1_prod[HPROD_W-1:FRAC_BITS];
      v2 <= c2_fx[Q_W-1:FRAC_BITS];
      h2 <= h2_prod[HPROD_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      next_channel       <= channel_index;
      throttle_above     <= (throttle_sample > throttle_threshold);
      voltages_updated   <= updated;
      cap_one_volts      <= v1;
      cap_one_hundredths <= h1;
      cap_two_volts      <= v2;
      cap_two_hundredths <= h2;
    end
  end

  a_update_wraps: assert property (@(posedge clk) disable iff (rst)
    result_valid && voltages_updated |-> next_channel == CH_THROTTLE)
    else $error("voltage update without return to throttle channel");

  a_hund_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cap_one_hundredths <= HUND_W'(99) && cap_two_hundredths <= HUND_W'(99))
    else $error("hundredths out of range");

  a_cap_one_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cap_one_volts <= VOLTS_W'(16))
    else $error("capacitor one volts out of range");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    div_last |=> state == ST_SPLIT || state == ST_EMIT)
    else $error("divider did not finish on last bit");

endmodule
